/* src/afs_pkg.sv */
// ----------------------------------------------------------------------------
// afs_pkg: shared types and constants for the animation frame sequencer
// Item and result payloads, operation codes, register indexes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package afs_pkg;

    // Fixed field widths
    localparam int AMOUNT_W  = 16;
    localparam int SLOT_W    = 4;
    localparam int INDEX_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    // Item operations
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_END   = 2'd2,
        OP_WRITE = 2'd3
    } t_op;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_START   = 2'd2;

    typedef struct packed {
        t_op                 op;
        logic [AMOUNT_W-1:0] amount;
        logic [SLOT_W-1:0]   frame_slot;
    } t_item;

    typedef struct packed {
        logic [INDEX_W-1:0] frame_index;
        logic               changed;
        logic               past_intro;
        logic               done_res;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture the item
        logic exec;   // carry out the operation / set up a tick
        logic rd;     // read tables at the current frame
        logic eval;   // spend ticks on the current frame
    } t_ctl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic run_tick;   // tick has ticks to spend
        logic step_last;  // this frame step ends the tick
    } t_dp_stat;

endpackage

/* src/afs_ram.sv */
// ----------------------------------------------------------------------------
// afs_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module afs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/afs_ctrl.sv */
// ----------------------------------------------------------------------------
// afs_ctrl: sequencer controller
// Steps each item through execute, per-frame read/evaluate and result.
// ----------------------------------------------------------------------------
module afs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output logic             o_res_valid,
    input  afs_pkg::t_dp_stat i_stat,
    output afs_pkg::t_ctl_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD,
        S_EVAL,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    logic   r_res_vld;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_stat.run_tick ? S_RD : S_OUT;
            end
            S_RD: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = i_stat.step_last ? S_OUT : S_RD;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_busy    <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_busy    <= (n_state != S_IDLE);
            r_res_vld <= (n_state == S_OUT);
        end
    end

    // Datapath commands
    always_comb begin
        o_cmd.load = (r_state == S_IDLE) && start;
        o_cmd.exec = (r_state == S_EXEC);
        o_cmd.rd   = (r_state == S_RD);
        o_cmd.eval = (r_state == S_EVAL);
    end

    assign busy        = r_busy;
    assign o_res_valid = r_res_vld;

`ifndef SYNTHESIS
    // Result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |=> !r_res_vld)
        else $error("result strobe held longer than one cycle");

    // After a result the block is free again
    a_free_after_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |=> !r_busy)
        else $error("busy after result transfer");

    // An accepted item makes the block busy
    a_busy_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !r_busy) |=> r_busy)
        else $error("item accepted but not busy");

    // Strobe only while busy
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |-> r_busy)
        else $error("result strobe while idle");
`endif

endmodule

/* src/afs_dp.sv */
// ----------------------------------------------------------------------------
// afs_dp: sequencer datapath
// Configuration registers, delay and elapsed tables, frame index, flags and
// the per-frame tick arithmetic.
// ----------------------------------------------------------------------------
module afs_dp #(
    parameter int MAX_FRAMES = 16,
    parameter int DELAY_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  afs_pkg::t_ctl_cmd                   i_cmd,
    output afs_pkg::t_dp_stat                   o_stat,
    input  afs_pkg::t_item                      i_item,
    input  logic                                i_cfg_valid,
    input  logic [afs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [afs_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    output afs_pkg::t_result                    o_result
);

    localparam int FW  = $clog2(MAX_FRAMES);
    localparam int CW  = $clog2(MAX_FRAMES + 1);
    localparam int XW0 = (FW + 1 > CW) ? FW + 1 : CW;
    localparam int XW  = (XW0 > 5) ? XW0 : 5;
    localparam int AW  = afs_pkg::AMOUNT_W;
    localparam int SW  = (DELAY_BITS > AW) ? DELAY_BITS : AW;

    // Registers
    afs_pkg::t_item  r_item;
    logic [4:0]      r_fc, r_ls, r_es;
    logic [FW-1:0]   r_cur;
    logic            r_done, r_intro, r_chg;
    logic [AW-1:0]   r_rem;
    logic [MAX_FRAMES-1:0] r_el_vld;
    logic            r_vld_q;

    // Table read data
    logic [DELAY_BITS-1:0] dly_q, el_q;

    // Count, jump targets
    logic [XW-1:0] fc_x, max_x, n_x, last_x, ls_x, es_x, ls_clamp, es_clamp, cur_x;
    logic          ls_ok, es_ok, skip, intro_new;

    always_comb begin
        fc_x     = XW'(r_fc);
        max_x    = XW'(MAX_FRAMES);
        n_x      = (fc_x > max_x) ? max_x : fc_x;
        last_x   = (n_x != '0) ? n_x - XW'(1) : '0;
        ls_ok    = !r_ls[4];
        es_ok    = !r_es[4];
        ls_x     = XW'(r_ls[3:0]);
        es_x     = XW'(r_es[3:0]);
        ls_clamp = (ls_x > last_x) ? last_x : ls_x;
        es_clamp = (es_x > last_x) ? last_x : es_x;
        cur_x    = XW'(r_cur);
        skip     = (n_x < XW'(2)) || r_done;
        intro_new = !ls_ok || (cur_x >= ls_x);
    end

    // Delay write value: zero becomes one, saturate to the table width
    logic [SW-1:0] wr_v, wr_max, wr_sat;
    logic [XW-1:0] slot_x;
    logic          slot_ok, dly_we;

    always_comb begin
        wr_v    = (r_item.amount == '0) ? SW'(1) : SW'(r_item.amount);
        wr_max  = {SW{1'b1}} >> (SW - DELAY_BITS);
        wr_sat  = (wr_v > wr_max) ? wr_max : wr_v;
        slot_x  = XW'(r_item.frame_slot);
        slot_ok = slot_x < max_x;
        dly_we  = i_cmd.exec && (r_item.op == afs_pkg::OP_WRITE) && slot_ok;
    end

    // One frame step of a tick
    logic [DELAY_BITS-1:0] el_v, need;
    logic [SW-1:0]         need_s, rem_s, el_sum;
    logic [AW-1:0]         rem_left;
    logic [XW-1:0]         nxt0, nxt1, nxt2;
    logic                  partial, hit_end, wrap, finish_cnt;

    always_comb begin
        el_v       = r_vld_q ? el_q : '0;
        need       = (dly_q > el_v) ? dly_q - el_v : '0;
        need_s     = SW'(need);
        rem_s      = SW'(r_rem);
        partial    = need_s > rem_s;
        rem_left   = AW'(rem_s - need_s);
        el_sum     = SW'(el_v) + rem_s;
        nxt0       = cur_x + XW'(1);
        // first end-segment frame wraps to the loop
        nxt1       = (es_ok && ls_ok && (nxt0 == es_x)) ? ls_clamp : nxt0;
        hit_end    = nxt1 >= n_x;
        wrap       = !es_ok && ls_ok;
        finish_cnt = hit_end && !wrap;
        nxt2       = hit_end ? (wrap ? ls_clamp : last_x) : nxt1;
    end

    assign o_stat.run_tick  = (r_item.op == afs_pkg::OP_TICK) && !skip &&
                              (r_item.amount != '0);
    assign o_stat.step_last = partial || finish_cnt || (rem_left == '0);

    // Tables
    afs_ram #(
        .WIDTH (DELAY_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_dly_ram (
        .i_clk   (i_clk),
        .i_we    (dly_we),
        .i_waddr (slot_x[FW-1:0]),
        .i_wdata (wr_sat[DELAY_BITS-1:0]),
        .i_re    (i_cmd.rd),
        .i_raddr (r_cur),
        .o_rdata (dly_q)
    );

    afs_ram #(
        .WIDTH (DELAY_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_el_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.eval && partial),
        .i_waddr (r_cur),
        .i_wdata (el_sum[DELAY_BITS-1:0]),
        .i_re    (i_cmd.rd),
        .i_raddr (r_cur),
        .o_rdata (el_q)
    );

    // Control state: config, frame index, flags, elapsed valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc     <= '0;
            r_ls     <= 5'b11111;
            r_es     <= 5'b11111;
            r_cur    <= '0;
            r_done   <= 1'b0;
            r_intro  <= 1'b0;
            r_chg    <= 1'b0;
            r_el_vld <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    afs_pkg::CFG_FRAME_COUNT: r_fc <= i_cfg_data;
                    afs_pkg::CFG_LOOP_START:  r_ls <= i_cfg_data;
                    afs_pkg::CFG_END_START:   r_es <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.exec) begin
                r_chg <= 1'b0;
                unique case (r_item.op)
                    afs_pkg::OP_TICK: begin
                        if (!skip) r_intro <= intro_new;
                    end
                    afs_pkg::OP_START: begin
                        r_cur       <= '0;
                        r_el_vld[0] <= 1'b0;
                    end
                    afs_pkg::OP_END: begin
                        if (es_ok) r_cur <= es_clamp[FW-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.eval) begin
                if (partial) begin
                    r_el_vld[r_cur] <= 1'b1;
                end else begin
                    r_el_vld[r_cur] <= 1'b0;
                    r_chg           <= 1'b1;
                    r_cur           <= nxt2[FW-1:0];
                    if (finish_cnt) r_done <= 1'b1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_item;
        if (i_cmd.exec) r_rem <= r_item.amount;
        if (i_cmd.eval) r_rem <= rem_left;
        if (i_cmd.rd)   r_vld_q <= r_el_vld[r_cur];
    end

    // Result
    logic [FW+3:0] cur_w;
    assign cur_w                = (FW + 4)'(r_cur);
    assign o_result.frame_index = cur_w[3:0];
    assign o_result.changed     = r_chg;
    assign o_result.past_intro  = r_intro;
    assign o_result.done_res    = r_done;

`ifndef SYNTHESIS
    // Finished is sticky until reset
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("finished flag dropped");
`endif

endmodule

/* src/animation_frame_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// animation_frame_sequencer_unit: animation frame sequencer
// Steps a frame index through a per-frame delay table with loop and end
// segments; ticks are spent across as many frames as they cover.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// item      in         start && !busy            i_item (afs_pkg::t_item)
// result    out        o_res_valid (1 cycle)     o_result (afs_pkg::t_result)
// config    in         i_cfg_valid && o_cfg_ready i_cfg_index, i_cfg_data
//
// Start, end and delay-write items pass through execute and then the result state;
// the result strobes while the controller is in that result state.
// A tick adds a read and an evaluate state for each frame it steps through: each
// frame step reads the delay and elapsed RAMs (registered read) then updates.
// Synchronous active-low reset; elapsed counts clear at once through
// per-frame valid bits, so there is no clearing pass.
// Results cannot be held off; config is always ready.
// ----------------------------------------------------------------------------
module animation_frame_sequencer_unit #(
    parameter int MAX_FRAMES = 16,
    parameter int DELAY_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  afs_pkg::t_item                i_item,
    output logic                          o_res_valid,
    output afs_pkg::t_result              o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [afs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [afs_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    afs_pkg::t_ctl_cmd cmd;
    afs_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    afs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .o_res_valid (o_res_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    afs_dp #(
        .MAX_FRAMES (MAX_FRAMES),
        .DELAY_BITS (DELAY_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_result)
    );

endmodule
